// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries concurrent checks.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, skipped while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/gmcb_pkg.sv -----
// Types, codes and helpers for the G-code modal motion command builder.
// Used by every module of the block; depends on nothing.
package gmcb_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int CMD_SLOTS      = 3;

    // Reset values of the configuration registers and the feed state
    localparam logic [15:0] POWER_LIMIT_RST  = 16'd1000;
    localparam logic [31:0] RAPID_FEED_RST   = 32'd196608000;
    localparam logic [31:0] DEFAULT_FEED_RST = 32'd65536000;
    localparam logic [1:0]  CMD_CAP_RST      = 2'd3;

    typedef enum logic [1:0] {
        CFG_POWER_LIMIT  = 2'd0,
        CFG_RAPID_FEED   = 2'd1,
        CFG_DEFAULT_FEED = 2'd2,
        CFG_MAX_COMMANDS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FUNC_LINE     = 2'd0,
        FUNC_FEEDBACK = 2'd1,
        FUNC_ESTOP    = 2'd2,
        FUNC_UNUSED   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_LASER_ON  = 3'd0,
        KIND_LASER_OFF = 3'd1,
        KIND_ORIGIN    = 3'd2,
        KIND_RAPID     = 3'd3,
        KIND_FEED      = 3'd4,
        KIND_STOP      = 3'd5
    } t_kind;

    localparam logic [6:0] G_RAPID   = 7'd0;
    localparam logic [6:0] G_FEED    = 7'd1;
    localparam logic [6:0] G_ABS     = 7'd90;
    localparam logic [6:0] G_REL     = 7'd91;
    localparam logic [6:0] G_ORIGIN  = 7'd92;
    localparam logic [6:0] M_LASER_ON  = 7'd3;
    localparam logic [6:0] M_LASER_DYN = 7'd4;
    localparam logic [6:0] M_LASER_OFF = 7'd5;

    typedef struct packed {
        logic [1:0]         func;
        logic               has_feed;
        logic [31:0]        feed_value;
        logic               has_power;
        logic signed [31:0] power_value;
        logic [6:0]         m_code;
        logic [6:0]         g_code;
        logic               has_x;
        logic signed [31:0] x_value;
        logic               has_y;
        logic signed [31:0] y_value;
    } t_item;

    typedef struct packed {
        t_kind              command_kind;
        logic [15:0]        sequence_res;
        logic               laser_flag;
        logic               absolute_flag;
        logic signed [31:0] target_x_out;
        logic signed [31:0] target_y_out;
        logic [31:0]        feed_out;
        logic [15:0]        power_out;
        logic               last_command;
    } t_cmd;

    // Modal state other than the positions, whose width is a parameter
    typedef struct packed {
        logic        laser_en;
        logic        abs_mode;
        logic [31:0] feed_cur;
        logic [31:0] laser_power;
        logic [15:0] seq;
    } t_state;

    typedef struct packed {
        logic [15:0] power_limit;
        logic [31:0] rapid_feed;
        logic [1:0]  max_commands;
    } t_cfg;

    // Sequence numbers skip zero
    function automatic logic [15:0] seq_fix(input logic [15:0] s);
        return (s == 16'd0) ? 16'd1 : s;
    endfunction

    function automatic t_cmd mk_cmd(input t_kind kind, input logic [15:0] seq,
                                    input logic laser, input logic absm,
                                    input logic [31:0] tx, input logic [31:0] ty,
                                    input logic [31:0] feed, input logic [15:0] pwr);
        t_cmd c;
        c.command_kind  = kind;
        c.sequence_res  = seq;
        c.laser_flag    = laser;
        c.absolute_flag = absm;
        c.target_x_out  = tx;
        c.target_y_out  = ty;
        c.feed_out      = feed;
        c.power_out     = pwr;
        c.last_command  = 1'b0;
        return c;
    endfunction

endpackage

// ----- hw/rtl/gmcb_stream_if.sv -----
// Valid/ready channel carrying one request payload of a given type.
// Depends on nothing; the payload type comes in as a parameter.
interface gmcb_stream_if #(parameter type T_PAYLOAD = logic);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/gmcb_step.sv -----
// Modal interpreter logic: one held request and the current state in,
// next state and up to three commands out. Uses gmcb_pkg.
module gmcb_step
    import gmcb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  t_item                  i_item,
    input  t_state                 i_st,
    input  logic [COORD_BITS-1:0]  i_pos_x,
    input  logic [COORD_BITS-1:0]  i_pos_y,
    input  t_cfg                   i_cfg,
    output t_state                 o_nxt,
    output logic [COORD_BITS-1:0]  o_nxt_x,
    output logic [COORD_BITS-1:0]  o_nxt_y,
    output t_cmd                   o_cmds [CMD_SLOTS],
    output logic [1:0]             o_cnt
);

    logic [1:0]            cnt;
    logic [15:0]           seq;
    logic [COORD_BITS-1:0] xe, ye, tx, ty;
    logic                  moved;
    logic [31:0]           pv, lim;
    logic [1:0]            cap;

    assign xe  = COORD_BITS'(i_item.x_value);
    assign ye  = COORD_BITS'(i_item.y_value);
    assign lim = {i_cfg.power_limit, 16'h0000};
    assign cap = i_cfg.max_commands;

    always_comb begin
        o_nxt   = i_st;
        o_nxt_x = i_pos_x;
        o_nxt_y = i_pos_y;
        o_cmds  = '{default: '0};
        cnt     = 2'd0;
        seq     = i_st.seq;
        tx      = i_pos_x;
        ty      = i_pos_y;
        moved   = 1'b0;
        pv      = 32'(unsigned'(i_item.power_value));

        case (i_item.func)
            FUNC_FEEDBACK: begin
                o_nxt_x = xe;
                o_nxt_y = ye;
            end
            FUNC_ESTOP: begin
                // stop carries the flags from before the stop
                o_cmds[0] = mk_cmd(KIND_STOP, seq_fix(seq), i_st.laser_en, i_st.abs_mode,
                                   32'd0, 32'd0, 32'd0, 16'd0);
                seq = seq_fix(seq) + 16'd1;
                cnt = 2'd1;
                o_nxt.laser_en    = 1'b0;
                o_nxt.laser_power = 32'd0;
            end
            FUNC_LINE: begin
                if (cap != 2'd0) begin
                    if (i_item.has_feed) begin
                        o_nxt.feed_cur = i_item.feed_value;
                    end

                    if (i_item.has_power) begin
                        if (pv[31]) begin
                            pv = 32'd0;
                        end else if (pv > lim) begin
                            pv = lim;
                        end
                        o_nxt.laser_power = pv;
                        // re-emit laser-on with the new power
                        if (o_nxt.laser_en && cnt < cap) begin
                            o_cmds[cnt] = mk_cmd(KIND_LASER_ON, seq_fix(seq), o_nxt.laser_en,
                                                 o_nxt.abs_mode, 32'd0, 32'd0, 32'd0,
                                                 pv[31:16]);
                            seq = seq_fix(seq) + 16'd1;
                            cnt = cnt + 2'd1;
                        end
                    end

                    if ((i_item.m_code == M_LASER_ON || i_item.m_code == M_LASER_DYN)
                        && cnt < cap) begin
                        o_nxt.laser_en = 1'b1;
                        o_cmds[cnt] = mk_cmd(KIND_LASER_ON, seq_fix(seq), 1'b1, o_nxt.abs_mode,
                                             32'd0, 32'd0, 32'd0, o_nxt.laser_power[31:16]);
                        seq = seq_fix(seq) + 16'd1;
                        cnt = cnt + 2'd1;
                    end else if (i_item.m_code == M_LASER_OFF && cnt < cap) begin
                        o_nxt.laser_en = 1'b0;
                        o_cmds[cnt] = mk_cmd(KIND_LASER_OFF, seq_fix(seq), 1'b0,
                                             o_nxt.abs_mode, 32'd0, 32'd0, 32'd0, 16'd0);
                        seq = seq_fix(seq) + 16'd1;
                        cnt = cnt + 2'd1;
                    end

                    case (i_item.g_code)
                        G_ABS: begin
                            o_nxt.abs_mode = 1'b1;
                        end
                        G_REL: begin
                            o_nxt.abs_mode = 1'b0;
                        end
                        G_ORIGIN: begin
                            if (cnt < cap) begin
                                o_cmds[cnt] = mk_cmd(KIND_ORIGIN, seq_fix(seq), o_nxt.laser_en,
                                                     o_nxt.abs_mode, 32'd0, 32'd0, 32'd0,
                                                     16'd0);
                                seq = seq_fix(seq) + 16'd1;
                                cnt = cnt + 2'd1;
                                o_nxt_x = '0;
                                o_nxt_y = '0;
                            end
                        end
                        G_RAPID, G_FEED: begin
                            if (i_item.has_x) begin
                                tx    = o_nxt.abs_mode ? xe : i_pos_x + xe;
                                moved = 1'b1;
                            end
                            if (i_item.has_y) begin
                                ty    = o_nxt.abs_mode ? ye : i_pos_y + ye;
                                moved = 1'b1;
                            end
                            if (moved && cnt < cap) begin
                                o_cmds[cnt] = mk_cmd(
                                    (i_item.g_code == G_RAPID) ? KIND_RAPID : KIND_FEED,
                                    seq_fix(seq), o_nxt.laser_en, o_nxt.abs_mode,
                                    32'(signed'(tx)), 32'(signed'(ty)),
                                    (i_item.g_code == G_RAPID) ? i_cfg.rapid_feed
                                                               : o_nxt.feed_cur,
                                    o_nxt.laser_power[31:16]);
                                seq = seq_fix(seq) + 16'd1;
                                cnt = cnt + 2'd1;
                                o_nxt_x = tx;
                                o_nxt_y = ty;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        o_nxt.seq = seq;
        o_cnt     = cnt;
    end

endmodule

// ----- hw/rtl/gmcb_emit.sv -----
// Result register: holds up to three commands of one request and sends them out
// one per cycle while ready, marking the final one. Uses gmcb_pkg and gmcb_stream_if.
module gmcb_emit
    import gmcb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [1:0]           i_load_cnt,
    input  t_cmd                 i_load_cmds [CMD_SLOTS],
    output logic                 o_free,
    gmcb_stream_if.source        o_cmd
);

    logic [1:0] r_cnt;
    t_cmd       r_slot [CMD_SLOTS];
    t_cmd       n_slot [CMD_SLOTS];
    logic       pop;

    assign pop    = o_cmd.valid && o_cmd.ready;
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    assign o_cmd.valid   = (r_cnt != 2'd0);
    assign o_cmd.payload = r_slot[0];

    always_comb begin
        for (int k = 0; k < CMD_SLOTS; k++) begin
            n_slot[k] = i_load_cmds[k];
            n_slot[k].last_command = (2'(k) == i_load_cnt - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_load_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // advance the queue head on every taken command
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= n_slot;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

// ----- hw/rtl/gcode_modal_motion_command_builder_unit.sv -----
// Top level of the G-code modal motion command builder.
// Uses gmcb_pkg, gmcb_stream_if, gmcb_step, gmcb_emit and assert_macros.svh.
//
// Takes one request per cycle on i_line (parsed line, position feedback or
// emergency stop) into an input register while that register is free or
// its request advances; the modal logic then updates the state and loads
// the request's commands (up to three) into the result register, from which
// the first command shows on o_cmd. Commands leave one per cycle while o_cmd
// is ready; the input register waits only while a previous request still
// has commands queued. Requests without commands do not wait for the result
// register. Configuration writes take effect on the next cycle and are meant
// for idle periods; default_feed only sets the feed at reset.
`include "assert_macros.svh"

module gcode_modal_motion_command_builder_unit
    import gmcb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    gmcb_stream_if.sink   i_line,
    gmcb_stream_if.source o_cmd
);

    t_cfg                  r_cfg;
    t_state                r_st;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y;
    t_item                 r_item;
    logic                  r_in_vld;

    t_state                n_st;
    logic [COORD_BITS-1:0] n_pos_x, n_pos_y;
    t_cmd                  step_cmds [CMD_SLOTS];
    logic [1:0]            step_cnt;
    logic                  emit_free;
    logic                  advance;

    logic                  seq_ok;
    logic                  line_adv;
    logic                  stop_adv;
    logic                  cap_ok;
    logic                  cmd_more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_limit  <= POWER_LIMIT_RST;
            r_cfg.rapid_feed   <= RAPID_FEED_RST;
            r_cfg.max_commands <= CMD_CAP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_POWER_LIMIT:  r_cfg.power_limit  <= i_cfg_data[15:0];
                CFG_RAPID_FEED:   r_cfg.rapid_feed   <= i_cfg_data;
                CFG_MAX_COMMANDS: r_cfg.max_commands <= i_cfg_data[1:0];
                // default feed is reloaded only by reset, which restores it too
                default: begin
                end
            endcase
        end
    end

    // drop the held request once its commands fit into the result register
    assign advance      = r_in_vld && (step_cnt == 2'd0 || emit_free);
    assign i_line.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_line.ready) begin
            r_in_vld <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.valid && i_line.ready) begin
            r_item <= i_line.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.laser_en    <= 1'b0;
            r_st.abs_mode    <= 1'b1;
            r_st.feed_cur    <= DEFAULT_FEED_RST;
            r_st.laser_power <= 32'd0;
            r_st.seq         <= 16'd1;
            r_pos_x          <= '0;
            r_pos_y          <= '0;
        end else if (advance) begin
            r_st    <= n_st;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

    gmcb_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_item  (r_item),
        .i_st    (r_st),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_cfg   (r_cfg),
        .o_nxt   (n_st),
        .o_nxt_x (n_pos_x),
        .o_nxt_y (n_pos_y),
        .o_cmds  (step_cmds),
        .o_cnt   (step_cnt)
    );

    gmcb_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && step_cnt != 2'd0),
        .i_load_cnt  (step_cnt),
        .i_load_cmds (step_cmds),
        .o_free      (emit_free),
        .o_cmd       (o_cmd)
    );

    assign seq_ok   = (o_cmd.payload.sequence_res != 16'd0);
    assign line_adv = advance && (r_item.func == FUNC_LINE);
    assign stop_adv = advance && (r_item.func == FUNC_ESTOP);
    assign cap_ok   = (step_cnt <= r_cfg.max_commands);
    assign cmd_more = o_cmd.valid && o_cmd.ready && !o_cmd.payload.last_command;

    `ASSERT_CLK(a_seq_nonzero, i_clk, i_rst_n, o_cmd.valid |-> seq_ok, "zero sequence number")
    `ASSERT_CLK(a_cap_kept, i_clk, i_rst_n, line_adv |-> cap_ok, "line over command cap")
    `ASSERT_CLK(a_more_follow, i_clk, i_rst_n, cmd_more |=> o_cmd.valid, "stream broke early")
    `ASSERT_CLK(a_stop_single, i_clk, i_rst_n, stop_adv |-> step_cnt == 2'd1, "stop not single")

endmodule
